FILE: src/tecl_pkg.sv
// ----------------------------------------------------------------------------
// tecl_pkg: shared types and constants of the tab expanded column locator
// Holds the sequencer and line phase codes, field widths, reset values and
// the request and result structs of the shared remainder unit.
// ----------------------------------------------------------------------------
package tecl_pkg;

  // Widths fixed by the item fields
  localparam int TARGET_W  = 16;
  localparam int CHARS_W   = 16;
  localparam int INDEX_W   = 16;
  localparam int SPACES_W  = 8;
  localparam int CHAR_W    = 8;
  localparam int TABW_W    = 8;

  // Default counter width
  localparam int COLUMN_BITS_DEF = 16;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_TAB_WIDTH = 1'b0;  // register index taken from paddr[2]

  // Codes and reset values
  localparam logic [CHAR_W-1:0] TAB_CODE      = 8'd9;
  localparam logic [TABW_W-1:0] TAB_WIDTH_RST = 8'd8;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_EMIT
  } state_t;

  // Line phase
  typedef enum logic [1:0] {
    PH_SEEK,
    PH_COUNT,
    PH_DONE
  } phase_t;

  // Remainder unit request and result
  typedef struct packed {
    logic              start;
    logic [TABW_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [TABW_W-1:0] rem;
  } mod_res_t;

endpackage

FILE: src/tecl_mod_unit.sv
// ----------------------------------------------------------------------------
// tecl_mod_unit: bit-serial remainder unit
// Restoring division of a DVD_W bit value by an 8 bit nonzero divisor,
// one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module tecl_mod_unit
  import tecl_pkg::*;
#(
  parameter int DVD_W = COLUMN_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mod_req_t         req,
  input  logic [DVD_W-1:0] dividend,
  output mod_res_t         res
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [TABW_W-1:0] div_r, div_nxt;
  logic [TABW_W-1:0] rem_r, rem_nxt;
  logic [TABW_W:0]   trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[DVD_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      dvd_nxt  = dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = TABW_W'(trial - {1'b0, div_r});
        end else begin
          rem_nxt = trial[TABW_W-1:0];
        end
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  // Report the remainder once all bits are in
  assign res.done = busy_r && (cnt_r == '0);
  assign res.rem  = rem_r;

endmodule

FILE: src/tab_expanded_column_locator.sv
// ----------------------------------------------------------------------------
// tab_expanded_column_locator: source index at a display column of a line
// Plain characters, end markers and items after the result bypass the
// remainder unit; a tab while seeking, or a target found passed or on a
// tab, goes through the shared remainder unit. A result is loaded into the
// output register once that register no longer holds a stalled result.
// Reset (rst_n low, synchronous) closes the line, clears counters, tab_width=8.
// ----------------------------------------------------------------------------
module tab_expanded_column_locator
  import tecl_pkg::*;
#(
  parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic                  in_end_of_line,
  input  logic [TARGET_W-1:0]   in_target_column,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [INDEX_W-1:0]    out_source_index,
  output logic [CHARS_W-1:0]    out_remaining_chars,
  output logic [SPACES_W-1:0]   out_remaining_spaces,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CMP_W  = (COLUMN_BITS > TARGET_W) ? COLUMN_BITS : TARGET_W;
  localparam int WIDE_W = COLUMN_BITS + INDEX_W;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic                   line_open_r, line_open_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [COLUMN_BITS-1:0] pos_r, pos_nxt;
  logic [COLUMN_BITS-1:0] run_r, run_nxt;
  logic [TARGET_W-1:0]    tgt_r, tgt_nxt;
  logic [TABW_W-1:0]      tabw_r;
  logic [TABW_W-1:0]      tw_cur_r, tw_cur_nxt;
  logic                   spaces_op_r, spaces_op_nxt;

  logic [COLUMN_BITS-1:0] pend_idx_r, pend_idx_nxt;
  logic [COLUMN_BITS-1:0] pend_chars_r, pend_chars_nxt;
  logic [SPACES_W-1:0]    pend_spaces_r, pend_spaces_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [CHARS_W-1:0]     out_chars_r, out_chars_nxt;
  logic [SPACES_W-1:0]    out_spaces_r, out_spaces_nxt;

  logic                   accept;
  logic                   is_tab;
  logic [TARGET_W-1:0]    tgt_eff;
  logic [TABW_W-1:0]      tw_eff;
  logic [CMP_W-1:0]       col_ext;
  logic [CMP_W-1:0]       tgt_ext;
  logic                   reached;
  logic                   beyond;
  logic                   need_mod;
  logic                   out_free;
  logic [TABW_W-1:0]      tab_step;
  logic [COLUMN_BITS:0]   col_sum;
  logic [COLUMN_BITS-1:0] col_tab;
  logic [COLUMN_BITS-1:0] pos_inc;
  logic [COLUMN_BITS-1:0] col_inc;
  logic [COLUMN_BITS-1:0] run_inc;
  logic [WIDE_W-1:0]      pend_idx_wide;
  logic [WIDE_W-1:0]      pend_chars_wide;
  logic                   cfg_write;

  mod_req_t         mod_req;
  mod_res_t         mod_res;
  logic [CMP_W-1:0] mod_dividend;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_TAB_WIDTH);
  assign prdata    = (paddr[2] == REG_TAB_WIDTH) ? APB_DATA_W'(tabw_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tabw_r <= TAB_WIDTH_RST;
    end else if (cfg_write) begin
      tabw_r <= pwdata[TABW_W-1:0];
    end
  end

  // Decode the incoming item
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign is_tab   = (in_char_code == TAB_CODE);
  assign tgt_eff  = line_open_r ? tgt_r : in_target_column;
  assign tw_eff   = (tabw_r == '0) ? TABW_W'(1) : tabw_r;
  assign col_ext  = CMP_W'(col_r);
  assign tgt_ext  = CMP_W'(tgt_eff);
  assign reached  = (col_ext >= tgt_ext);
  assign beyond   = (col_ext > tgt_ext);
  assign need_mod = !in_end_of_line && (phase_r == PH_SEEK) &&
                    (reached ? (beyond || is_tab) : is_tab);
  assign out_free = !out_valid_r || !out_stall;

  // Saturating counter updates
  assign pos_inc  = (&pos_r) ? pos_r : pos_r + 1'b1;
  assign col_inc  = (&col_r) ? col_r : col_r + 1'b1;
  assign run_inc  = (&run_r) ? run_r : run_r + 1'b1;
  assign tab_step = tw_cur_r - mod_res.rem;
  assign col_sum  = (COLUMN_BITS+1)'(col_r) + (COLUMN_BITS+1)'(tab_step);
  assign col_tab  = col_sum[COLUMN_BITS] ? '1 : col_sum[COLUMN_BITS-1:0];

  // Shared remainder unit: column or target modulo tab width
  assign mod_req.start   = accept && need_mod;
  assign mod_req.divisor = tw_eff;
  assign mod_dividend    = reached ? tgt_ext : col_ext;

  tecl_mod_unit #(
    .DVD_W (CMP_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mod_req),
    .dividend (mod_dividend),
    .res      (mod_res)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_end_of_line) begin
            state_nxt = (phase_r inside {PH_SEEK, PH_COUNT}) ? ST_EMIT : ST_IDLE;
          end else if (phase_r == PH_COUNT) begin
            state_nxt = is_tab ? ST_EMIT : ST_IDLE;
          end else if (need_mod) begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (mod_res.done) begin
          state_nxt = spaces_op_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall = (state_r != ST_IDLE);
  end

  // Line counters and pending result
  always_comb begin
    phase_nxt       = phase_r;
    line_open_nxt   = line_open_r;
    col_nxt         = col_r;
    pos_nxt         = pos_r;
    run_nxt         = run_r;
    tgt_nxt         = tgt_r;
    tw_cur_nxt      = tw_cur_r;
    spaces_op_nxt   = spaces_op_r;
    pend_idx_nxt    = pend_idx_r;
    pend_chars_nxt  = pend_chars_r;
    pend_spaces_nxt = pend_spaces_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          tgt_nxt       = tgt_eff;
          line_open_nxt = 1'b1;
          tw_cur_nxt    = tw_eff;
          spaces_op_nxt = reached;
          if (in_end_of_line) begin
            // close the line, report the length or the run
            pend_idx_nxt    = pos_r;
            pend_chars_nxt  = (phase_r == PH_COUNT) ? run_r : '0;
            pend_spaces_nxt = '0;
            col_nxt         = '0;
            pos_nxt         = '0;
            run_nxt         = '0;
            phase_nxt       = PH_SEEK;
            line_open_nxt   = 1'b0;
          end else if (phase_r == PH_COUNT) begin
            if (is_tab) begin
              pend_idx_nxt    = pos_r;
              pend_chars_nxt  = run_r;
              pend_spaces_nxt = '0;
              phase_nxt       = PH_DONE;
            end else begin
              run_nxt = run_inc;
            end
          end else if (phase_r == PH_SEEK) begin
            if (reached) begin
              if (!(beyond || is_tab)) begin
                // target on a plain character: start counting the run
                run_nxt   = COLUMN_BITS'(1);
                phase_nxt = PH_COUNT;
              end
            end else if (!is_tab) begin
              col_nxt = col_inc;
              pos_nxt = pos_inc;
            end
          end
        end
      end
      ST_MOD: begin
        if (mod_res.done) begin
          if (spaces_op_r) begin
            pend_idx_nxt    = pos_r;
            pend_chars_nxt  = '0;
            pend_spaces_nxt = tw_cur_r - mod_res.rem;
            phase_nxt       = PH_DONE;
          end else begin
            // advance to the next tab stop
            col_nxt = col_tab;
            pos_nxt = pos_inc;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: load a pending result, drop it once taken
  assign pend_idx_wide   = WIDE_W'(pend_idx_r);
  assign pend_chars_wide = WIDE_W'(pend_chars_r);

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_idx_nxt    = out_idx_r;
    out_chars_nxt  = out_chars_r;
    out_spaces_nxt = out_spaces_r;
    if ((state_r == ST_EMIT) && out_free) begin
      out_valid_nxt  = 1'b1;
      out_idx_nxt    = pend_idx_wide[INDEX_W-1:0];
      out_chars_nxt  = pend_chars_wide[CHARS_W-1:0];
      out_spaces_nxt = pend_spaces_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_SEEK;
      line_open_r <= 1'b0;
      col_r       <= '0;
      pos_r       <= '0;
      run_r       <= '0;
      tgt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      line_open_r <= line_open_nxt;
      col_r       <= col_nxt;
      pos_r       <= pos_nxt;
      run_r       <= run_nxt;
      tgt_r       <= tgt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tw_cur_r      <= tw_cur_nxt;
    spaces_op_r   <= spaces_op_nxt;
    pend_idx_r    <= pend_idx_nxt;
    pend_chars_r  <= pend_chars_nxt;
    pend_spaces_r <= pend_spaces_nxt;
    out_idx_r     <= out_idx_nxt;
    out_chars_r   <= out_chars_nxt;
    out_spaces_r  <= out_spaces_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_source_index     = out_idx_r;
  assign out_remaining_chars  = out_chars_r;
  assign out_remaining_spaces = out_spaces_r;

endmodule
